### design/ggc_pkg.sv
// Shared constants and types for the greedy graph coloring unit.
// No dependencies; imported by ggc_front, ggc_back, the top level and ggc_checker.
`default_nettype none

package ggc_pkg;

   localparam int DEF_MAX_NODES  = 1024;
   localparam int DEF_MAX_DEGREE = 63;

   localparam int NID_W       = 10;  // neighbor id port width
   localparam int VERTEX_W    = 10;  // vertex result port width
   localparam int COLOR_W     = 6;
   localparam int COUNT_W     = 6;   // degree counter, saturates at max degree
   localparam int NCOLORS     = 64;  // one mask bit per color
   localparam int VTX_MAX_W   = 16;  // vertex index width at the largest node count
   localparam int QUEUE_DEPTH = 2;

   // one classified item handed from the front end to the back end
   typedef struct packed {
      logic [NID_W-1:0]     nid;
      logic [VTX_MAX_W-1:0] vertex;   // vertex this item belongs to
      logic                 is_nbr;   // item carries a neighbor
      logic                 mark;     // neighbor already colored: read its color
      logic                 last;
      logic                 restart;
   } work_type;

   // one result item
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [COLOR_W-1:0]  color;
      logic                degree_overflow;
   } rsp_type;

endpackage

`default_nettype wire

### design/ggc_fifo.sv
// Small first-in first-out queue of registers.
// Generic: no package dependency.
`default_nettype none

module ggc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/ggc_front.sv
// Front end: accepts neighbor items, tracks the current vertex and
// classifies each neighbor as already colored or not. Uses ggc_pkg.
`default_nettype none

module ggc_front
   import ggc_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic             q_full,
   input  wire logic [NID_W-1:0] neighbor_id,
   input  wire logic             no_neighbor,
   input  wire logic             last_neighbor,
   input  wire logic             new_graph,
   output logic                  q_push,
   output work_type              q_data
);

   localparam int VW = $clog2(MAX_NODES);
   localparam int AW = (VW > NID_W) ? VW : NID_W;

   logic [VW-1:0] vertex_ff, vertex_in;
   logic [VW-1:0] base;
   logic          accept;

   assign accept = push && !q_full;
   assign base   = new_graph ? '0 : vertex_ff;

   always_comb begin
      vertex_in = vertex_ff;
      if (accept) begin
         vertex_in = base;
         if (last_neighbor) begin
            vertex_in = (base == VW'(MAX_NODES - 1)) ? '0 : base + VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff <= '0;
      end else begin
         vertex_ff <= vertex_in;
      end
   end

   assign q_push         = accept;
   assign q_data.nid     = neighbor_id;
   assign q_data.vertex  = VTX_MAX_W'(base);
   assign q_data.is_nbr  = !no_neighbor;
   // only vertices below the current one have a stored color
   assign q_data.mark    = !no_neighbor && (AW'(neighbor_id) < AW'(base));
   assign q_data.last    = last_neighbor;
   assign q_data.restart = new_graph;

endmodule

`default_nettype wire

### design/ggc_back.sv
// Back end: color store, used-color mask, degree count and first-fit
// selection; one classified item per cycle while out_full is low. Uses ggc_pkg.
`default_nettype none

module ggc_back
   import ggc_pkg::*;
#(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire work_type q_data,
   output logic          q_pop,
   input  wire logic     out_full,
   output logic          out_push,
   output rsp_type       out_data
);

   localparam int VW = $clog2(MAX_NODES);
   localparam int AW = (VW > NID_W) ? VW : NID_W;

   logic [COLOR_W-1:0] color_mem [MAX_NODES];

   logic               s1_valid_ff, s1_valid_in;
   work_type           s1_ff;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               byp_ff;
   logic [COLOR_W-1:0] byp_data_ff;

   logic [NCOLORS-1:0] mask_ff, mask_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;

   logic               s1_fire;
   logic [COLOR_W-1:0] nbr_color;
   logic [NCOLORS-1:0] mask_base, mask_next, low_zero;
   logic [COUNT_W-1:0] cnt_base, cnt_next;
   logic               ovf_base, ovf_next;
   logic [COLOR_W-1:0] low_idx, pick;
   logic               wr_en, rd_en;
   logic [VW-1:0]      wr_addr, rd_addr;
   logic [AW-1:0]      nid_ext;

   assign s1_fire = s1_valid_ff && (!s1_ff.last || !out_full);
   assign q_pop   = !q_empty && (!s1_valid_ff || s1_fire);

   // the color written by the item leaving now is not yet in the array
   assign nbr_color = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      mask_base = s1_ff.restart ? '0 : mask_ff;
      cnt_base  = s1_ff.restart ? '0 : cnt_ff;
      ovf_base  = s1_ff.restart ? 1'b0 : ovf_ff;
      mask_next = mask_base;
      cnt_next  = cnt_base;
      ovf_next  = ovf_base;
      if (s1_ff.is_nbr) begin
         if (cnt_base < COUNT_W'(MAX_DEGREE)) begin
            cnt_next = cnt_base + COUNT_W'(1);
         end else begin
            ovf_next = 1'b1;
         end
      end
      if (s1_ff.mark) begin
         mask_next = mask_base | (NCOLORS'(1) << nbr_color);
      end
   end

   // lowest clear bit as one-hot, then encoded
   assign low_zero = ~mask_next & (mask_next + NCOLORS'(1));

   always_comb begin
      low_idx = '0;
      for (int b = 0; b < COLOR_W; b++) begin
         for (int c = 0; c < NCOLORS; c++) begin
            if (((c >> b) & 1) == 1) begin
               low_idx[b] = low_idx[b] | low_zero[c];
            end
         end
      end
      pick = low_idx;
      if (low_zero == '0 || low_idx > cnt_next) begin
         pick = cnt_next;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      mask_in = mask_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (s1_fire) begin
         if (s1_ff.last) begin
            mask_in = '0;
            cnt_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            mask_in = mask_next;
            cnt_in  = cnt_next;
            ovf_in  = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mask_ff     <= '0;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mask_ff     <= mask_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
      end
   end

   assign nid_ext = AW'(q_data.nid);
   assign rd_addr = nid_ext[VW-1:0];
   assign rd_en   = q_pop && q_data.mark;
   assign wr_en   = s1_fire && s1_ff.last;
   assign wr_addr = s1_ff.vertex[VW-1:0];

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff       <= q_data;
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= pick;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         color_mem[wr_addr] <= pick;
      end
      if (rd_en) begin
         rd_data_ff <= color_mem[rd_addr];
      end
   end

   assign out_push                 = wr_en;
   assign out_data.vertex          = s1_ff.vertex[VERTEX_W-1:0];
   assign out_data.color           = pick;
   assign out_data.degree_overflow = ovf_next;

endmodule

`default_nettype wire

### design/greedy_graph_coloring_unit.sv
// Greedy first-fit graph coloring unit: top level.
// Uses ggc_pkg, ggc_fifo, ggc_front and ggc_back.
//
// Vertices are colored in index order. Each input item carries one neighbor id
// of the current vertex; the item flagged last yields one result with the
// smallest color not held by an already colored neighbor. The block takes one
// item per cycle and returns one result per cycle while neither queue is full:
// the front end and the back end each move an item every cycle, and the color
// store has one read and one write port and registered read data. The result
// of a last item is registered in the work queue, the back-end stage and the
// result queue before it shows on the result ports. Items and results are
// buffered in two-entry queues, so input keeps flowing while a result waits
// to be popped. The color store needs no clearing after reset.
`default_nettype none

module greedy_graph_coloring_unit
   import ggc_pkg::*;
#(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [NID_W-1:0]    req_neighbor_id,
   input  wire logic                req_no_neighbor,
   input  wire logic                req_last_neighbor,
   input  wire logic                req_new_graph,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [VERTEX_W-1:0]      rsp_vertex,
   output logic [COLOR_W-1:0]       rsp_color,
   output logic                     rsp_degree_overflow
);

   work_type front_data, work_data;
   logic     front_push, work_full, work_empty, work_pop;
   rsp_type  res_data, res_out;
   logic     res_push, res_full;

   ggc_front #(
      .MAX_NODES(MAX_NODES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .q_full        (work_full),
      .neighbor_id   (req_neighbor_id),
      .no_neighbor   (req_no_neighbor),
      .last_neighbor (req_last_neighbor),
      .new_graph     (req_new_graph),
      .q_push        (front_push),
      .q_data        (front_data)
   );

   ggc_fifo #(
      .WIDTH($bits(work_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_data),
      .empty     (work_empty)
   );

   ggc_back #(
      .MAX_NODES (MAX_NODES),
      .MAX_DEGREE(MAX_DEGREE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (work_empty),
      .q_data   (work_data),
      .q_pop    (work_pop),
      .out_full (res_full),
      .out_push (res_push),
      .out_data (res_data)
   );

   ggc_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign req_full            = work_full;
   assign rsp_vertex          = res_out.vertex;
   assign rsp_color           = res_out.color;
   assign rsp_degree_overflow = res_out.degree_overflow;

endmodule

`default_nettype wire

### design/ggc_checker.sv
// Port-level checks for the greedy graph coloring unit, bound to its top.
// Uses ggc_pkg.
`default_nettype none

module ggc_checker
   import ggc_pkg::*;
#(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_full,
   input wire logic                rsp_empty,
   input wire logic                rsp_pop,
   input wire logic [VERTEX_W-1:0] rsp_vertex,
   input wire logic [COLOR_W-1:0]  rsp_color,
   input wire logic                rsp_degree_overflow
);

   // both queues come out of reset empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_vertex)
         && $stable(rsp_color) && $stable(rsp_degree_overflow))
      else $error("waiting result changed");

   // the color never exceeds the degree, which saturates at the bound
   a_color_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_color) <= MAX_DEGREE))
      else $error("color above degree bound");

   // vertex zero has no colored neighbors
   a_first_vertex: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_vertex == '0) |-> (rsp_color == '0))
      else $error("vertex zero got a nonzero color");

   a_vertex_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_vertex) < MAX_NODES))
      else $error("vertex index out of range");

endmodule

bind greedy_graph_coloring_unit ggc_checker #(
   .MAX_NODES (MAX_NODES),
   .MAX_DEGREE(MAX_DEGREE)
) u_ggc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_vertex          (rsp_vertex),
   .rsp_color           (rsp_color),
   .rsp_degree_overflow (rsp_degree_overflow)
);

`default_nettype wire
